/* rtl/trz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_pkg
// Shared widths, job record and arithmetic helpers for the triangle rasterizer.
// ----------------------------------------------------------------------------
package trz_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int AREA_BITS    = PROD_BITS + 1;
    localparam int SUM_BITS     = AREA_BITS + 2;
    localparam int S_TDATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [AREA_BITS-1:0]  area_t;
    typedef logic [AREA_BITS-1:0]         mag_t;
    typedef logic [SUM_BITS-1:0]          sum_t;

    // one step request handed from the front end to the arithmetic back end
    typedef struct packed {
        logic   idle;
        logic   last;
        coord_t px;
        coord_t py;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by_coord;
        coord_t cx;
        coord_t cy;
    } trz_job_t;

    function automatic diff_t sub_c(input coord_t a, input coord_t b);
        sub_c = diff_t'({a[COORD_BITS-1], a}) - diff_t'({b[COORD_BITS-1], b});
    endfunction

    function automatic prod_t mul_d(input diff_t a, input diff_t b);
        mul_d = prod_t'(a) * prod_t'(b);
    endfunction

    function automatic mag_t abs_a(input area_t v);
        abs_a = v[AREA_BITS-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

endpackage

/* rtl/trz_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_queue
// Small job queue that decouples the scan front end from the back end.
// ----------------------------------------------------------------------------
module trz_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trz_pkg::trz_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output trz_pkg::trz_job_t head_job
);

    trz_pkg::trz_job_t                 entries [trz_pkg::QUEUE_DEPTH];
    logic [trz_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [trz_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [trz_pkg::QUEUE_AW:0]        count_reg;
    logic [trz_pkg::QUEUE_AW:0]        count_next;

    assign full      = (count_reg == (trz_pkg::QUEUE_AW+1)'(trz_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job queue read while empty");

endmodule

/* rtl/trz_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_front
// Command front end: latches triangles, keeps the box scan, issues step jobs.
// ----------------------------------------------------------------------------
module trz_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                command,
    input  trz_pkg::coord_t     ax,
    input  trz_pkg::coord_t     ay,
    input  trz_pkg::coord_t     bx,
    input  trz_pkg::coord_t     by_coord,
    input  trz_pkg::coord_t     cx,
    input  trz_pkg::coord_t     cy,
    output logic                push,
    output trz_pkg::trz_job_t   push_job
);

    trz_pkg::coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    trz_pkg::coord_t max_x_reg, min_y_reg, max_y_reg;
    trz_pkg::coord_t scan_x_reg, scan_y_reg;
    trz_pkg::coord_t scan_x_next, scan_y_next;
    logic            active_reg, active_next;
    trz_pkg::coord_t min_x, max_x, min_y, max_y;
    logic            is_load;
    logic            fin;
    logic            y_end;

    assign is_load = accept && (command == trz_pkg::CMD_LOAD);
    assign push    = accept && (command == trz_pkg::CMD_STEP);
    assign y_end   = (scan_y_reg >= max_y_reg);
    assign fin     = (scan_x_reg >= max_x_reg) && y_end;

    // bounding box of the incoming vertices
    always_comb
    begin
        min_x = (ax < bx) ? ax : bx;
        min_x = (min_x < cx) ? min_x : cx;
        max_x = (ax > bx) ? ax : bx;
        max_x = (max_x > cx) ? max_x : cx;
        min_y = (ay < by_coord) ? ay : by_coord;
        min_y = (min_y < cy) ? min_y : cy;
        max_y = (ay > by_coord) ? ay : by_coord;
        max_y = (max_y > cy) ? max_y : cy;
    end

    always_comb
    begin
        push_job.idle     = !active_reg;
        push_job.last     = !active_reg || fin;
        push_job.px       = active_reg ? scan_x_reg : '0;
        push_job.py       = active_reg ? scan_y_reg : '0;
        push_job.ax       = ax_reg;
        push_job.ay       = ay_reg;
        push_job.bx       = bx_reg;
        push_job.by_coord = by_reg;
        push_job.cx       = cx_reg;
        push_job.cy       = cy_reg;
    end

    always_comb
    begin
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        active_next = active_reg;
        if (is_load)
        begin
            scan_x_next = min_x;
            scan_y_next = min_y;
            active_next = 1'b1;
        end
        else if (push && active_reg)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else if (y_end)
            begin
                scan_y_next = min_y_reg;
                scan_x_next = scan_x_reg + 1'b1;
            end
            else
            begin
                scan_y_next = scan_y_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_x_reg <= '0;
            scan_y_reg <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            scan_x_reg <= scan_x_next;
            scan_y_reg <= scan_y_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            bx_reg    <= bx;
            by_reg    <= by_coord;
            cx_reg    <= cx;
            cy_reg    <= cy;
            max_x_reg <= max_x;
            min_y_reg <= min_y;
            max_y_reg <= max_y;
        end
    end

    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> active_reg)
        else $error("load did not start a scan");

    a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (scan_y_reg >= min_y_reg) && (scan_y_reg <= max_y_reg)
                       && (scan_x_reg <= max_x_reg))
        else $error("scan position left the bounding box");

endmodule

/* rtl/trz_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_back
// Three-stage inside test: edge products, sub-area magnitudes, sum and compare.
// ----------------------------------------------------------------------------
module trz_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  trz_pkg::trz_job_t           job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output trz_pkg::coord_t             out_px,
    output trz_pkg::coord_t             out_py,
    output logic                        out_inside,
    output logic                        out_last
);

    logic advance;

    // stage 1: products
    logic            s1_valid_reg;
    logic            s1_idle_reg, s1_last_reg;
    trz_pkg::coord_t s1_px_reg, s1_py_reg;
    trz_pkg::prod_t  s1_ab0_reg, s1_ab1_reg, s1_bc0_reg, s1_bc1_reg;
    trz_pkg::prod_t  s1_ca0_reg, s1_ca1_reg, s1_w0_reg, s1_w1_reg;

    // stage 2: magnitudes
    logic            s2_valid_reg;
    logic            s2_idle_reg, s2_last_reg;
    trz_pkg::coord_t s2_px_reg, s2_py_reg;
    trz_pkg::mag_t   s2_ab_reg, s2_bc_reg, s2_ca_reg, s2_w_reg;

    // stage 3: result register
    logic            out_valid_reg;
    logic            out_inside_reg, out_last_reg;
    trz_pkg::coord_t out_px_reg, out_py_reg;

    trz_pkg::sum_t   sub_sum;

    assign advance    = !out_valid_reg || out_ready;
    assign pop        = advance && job_valid;
    assign out_valid  = out_valid_reg;
    assign out_px     = out_px_reg;
    assign out_py     = out_py_reg;
    assign out_inside = out_inside_reg;
    assign out_last   = out_last_reg;

    assign sub_sum = trz_pkg::sum_t'(s2_ab_reg) + trz_pkg::sum_t'(s2_bc_reg)
                   + trz_pkg::sum_t'(s2_ca_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // edge cross products (B-A)x(P-A), (C-B)x(P-B), (A-C)x(P-C), (B-A)x(C-A)
            s1_ab0_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.bx, job.ax),
                                         trz_pkg::sub_c(job.py, job.ay));
            s1_ab1_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.by_coord, job.ay),
                                         trz_pkg::sub_c(job.px, job.ax));
            s1_bc0_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.cx, job.bx),
                                         trz_pkg::sub_c(job.py, job.by_coord));
            s1_bc1_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.cy, job.by_coord),
                                         trz_pkg::sub_c(job.px, job.bx));
            s1_ca0_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.ax, job.cx),
                                         trz_pkg::sub_c(job.py, job.cy));
            s1_ca1_reg <= trz_pkg::mul_d(trz_pkg::sub_c(job.ay, job.cy),
                                         trz_pkg::sub_c(job.px, job.cx));
            s1_w0_reg  <= trz_pkg::mul_d(trz_pkg::sub_c(job.bx, job.ax),
                                         trz_pkg::sub_c(job.cy, job.ay));
            s1_w1_reg  <= trz_pkg::mul_d(trz_pkg::sub_c(job.by_coord, job.ay),
                                         trz_pkg::sub_c(job.cx, job.ax));
            s1_idle_reg <= job.idle;
            s1_last_reg <= job.last;
            s1_px_reg   <= job.px;
            s1_py_reg   <= job.py;

            s2_ab_reg <= trz_pkg::abs_a(trz_pkg::area_t'(s1_ab0_reg)
                                        - trz_pkg::area_t'(s1_ab1_reg));
            s2_bc_reg <= trz_pkg::abs_a(trz_pkg::area_t'(s1_bc0_reg)
                                        - trz_pkg::area_t'(s1_bc1_reg));
            s2_ca_reg <= trz_pkg::abs_a(trz_pkg::area_t'(s1_ca0_reg)
                                        - trz_pkg::area_t'(s1_ca1_reg));
            s2_w_reg  <= trz_pkg::abs_a(trz_pkg::area_t'(s1_w0_reg)
                                        - trz_pkg::area_t'(s1_w1_reg));
            s2_idle_reg <= s1_idle_reg;
            s2_last_reg <= s1_last_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;

            out_inside_reg <= !s2_idle_reg
                              && (sub_sum == trz_pkg::sum_t'(s2_w_reg));
            out_last_reg   <= s2_last_reg;
            out_px_reg     <= s2_px_reg;
            out_py_reg     <= s2_py_reg;
        end
    end

endmodule

/* rtl/triangle_rasterizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_rasterizer_core
// Bounding-box triangle rasterizer with a one-position-per-clock step stream when not stalled.
// ----------------------------------------------------------------------------
// A load transaction (tuser = 0) latches three signed vertices, sets up the
// bounding box and restarts the scan at (min x, min y); it returns nothing.
// Each step transaction (tuser = 1) returns one result: the next box position
// (x outer, y inner, both ascending), an inside flag that is set when the three
// sub-triangle areas add up to the whole area, and tlast on the final box
// position. A step with no scan running returns zero coordinates, inside clear
// and tlast set. One transaction is taken per clock while the job queue is not
// full; a step result passes through the job queue write and then the three
// back-end stages (edge products, area magnitudes, sum and compare). A
// four-entry job queue sits between the scan front end and the back end, so
// input keeps flowing while a result waits on the output side, until it fills.
module triangle_rasterizer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [trz_pkg::S_TDATA_BITS-1:0]  s_tdata,  // ax, ay, bx, by_coord, cx, cy
    input  logic                              s_tuser,  // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [trz_pkg::M_TDATA_BITS-1:0]  m_tdata,  // px, py
    output logic                              m_tuser,  // inside_res
    output logic                              m_tlast
);

    localparam int CW = trz_pkg::COORD_BITS;

    logic              accept;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_not_empty;
    trz_pkg::trz_job_t push_job;
    trz_pkg::trz_job_t head_job;
    trz_pkg::coord_t   res_px, res_py;

    // input transaction when both sides agree
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    trz_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (s_tuser),
        .ax       (s_tdata[CW-1:0]),
        .ay       (s_tdata[2*CW-1:CW]),
        .bx       (s_tdata[3*CW-1:2*CW]),
        .by_coord (s_tdata[4*CW-1:3*CW]),
        .cx       (s_tdata[5*CW-1:4*CW]),
        .cy       (s_tdata[6*CW-1:5*CW]),
        .push     (q_push),
        .push_job (push_job)
    );

    // decouples scan bookkeeping from the arithmetic pipeline
    trz_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    trz_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_not_empty),
        .job        (head_job),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_px     (res_px),
        .out_py     (res_py),
        .out_inside (m_tuser),
        .out_last   (m_tlast)
    );

    // px in the low bits, zero fill up to whole bytes
    assign m_tdata = trz_pkg::M_TDATA_BITS'({res_py, res_px});

endmodule
